// ===== rtl/jsu_pkg.sv =====
`default_nettype none
package jsu_pkg;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_UNTERMINATED = 3'd0;
    localparam logic [2:0] ERR_END_ESCAPE   = 3'd1;
    localparam logic [2:0] ERR_SHORT_U      = 3'd2;
    localparam logic [2:0] ERR_NON_HEX      = 3'd3;
    localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd4;
    localparam logic [2:0] ERR_NONE         = 3'd0;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [7:0]  UTF_LEAD2   = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3   = 8'hE0;
    localparam logic [7:0]  UTF_CONT    = 8'h80;
    localparam logic [5:0]  UTF_MASK    = 6'h3F;
    localparam logic [15:0] CP_TWO_BYTE = 16'h0080;
    localparam logic [15:0] CP_THREE    = 16'h0800;

    // one run of up to three result words caused by one input word
    typedef struct packed {
        logic [1:0] last_idx;
        logic [1:0] kind;
        logic [2:0] err;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_run;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic       ok;
        logic [7:0] val;
    } t_esc;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.val = 4'(c - 8'h37);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic t_esc esc_decode(input logic [7:0] c);
        t_esc r;
        r.ok = 1'b1;
        unique case (c)
            CH_QUOTE:     r.val = 8'h22;
            CH_BACKSLASH: r.val = 8'h5C;
            CH_SLASH:     r.val = 8'h2F;
            8'h62:        r.val = 8'h08;
            8'h66:        r.val = 8'h0C;
            8'h6E:        r.val = 8'h0A;
            8'h72:        r.val = 8'h0D;
            8'h74:        r.val = 8'h09;
            default: begin
                r.ok  = 1'b0;
                r.val = 8'h00;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/jsu_front.sv =====
`default_nettype none
module jsu_front
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_start_string,
    input  wire logic       i_text_ended,
    output logic            o_run_valid,
    output t_run            o_run
);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_BODY = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    logic [1:0]  r_mode, n_mode;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [15:0] r_cp, n_cp;

    logic [1:0]  mode_eff;
    logic [1:0]  hex_eff;
    logic [15:0] cp_eff;
    logic [15:0] cp_full;
    t_hex        hx;
    t_esc        es;

    assign mode_eff = i_start_string ? MODE_BODY : r_mode;
    assign hex_eff  = i_start_string ? 2'd0 : r_hex_cnt;
    assign cp_eff   = i_start_string ? 16'd0 : r_cp;
    assign hx       = hex_decode(i_byte_value);
    assign es       = esc_decode(i_byte_value);
    assign cp_full  = {cp_eff[11:0], hx.val};

    always_comb begin
        n_mode      = mode_eff;
        n_hex_cnt   = hex_eff;
        n_cp        = cp_eff;
        o_run_valid = 1'b0;
        o_run       = '0;
        if (i_text_ended) begin
            n_mode    = MODE_IDLE;
            n_hex_cnt = 2'd0;
            n_cp      = 16'd0;
            o_run.kind = KIND_ERROR;
            unique case (mode_eff)
                MODE_BODY: begin
                    o_run_valid = 1'b1;
                    o_run.err   = ERR_UNTERMINATED;
                end
                MODE_ESC: begin
                    o_run_valid = 1'b1;
                    o_run.err   = ERR_END_ESCAPE;
                end
                MODE_HEX: begin
                    o_run_valid = 1'b1;
                    o_run.err   = ERR_SHORT_U;
                end
                default: begin
                    o_run_valid = 1'b0;
                end
            endcase
        end else begin
            unique case (mode_eff)
                MODE_BODY: begin
                    if (i_byte_value == CH_QUOTE) begin
                        o_run_valid = 1'b1;
                        o_run.kind  = KIND_CLOSE;
                        n_mode      = MODE_IDLE;
                        n_hex_cnt   = 2'd0;
                        n_cp        = 16'd0;
                    end else if (i_byte_value == CH_BACKSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        o_run_valid = 1'b1;
                        o_run.kind  = KIND_BYTE;
                        o_run.b0    = i_byte_value;
                    end
                end
                MODE_ESC: begin
                    if (es.ok) begin
                        o_run_valid = 1'b1;
                        o_run.kind  = KIND_BYTE;
                        o_run.b0    = es.val;
                        n_mode      = MODE_BODY;
                    end else if (i_byte_value == CH_U) begin
                        n_mode    = MODE_HEX;
                        n_hex_cnt = 2'd0;
                        n_cp      = 16'd0;
                    end else begin
                        o_run_valid = 1'b1;
                        o_run.kind  = KIND_ERROR;
                        o_run.err   = ERR_BAD_ESCAPE;
                        n_mode      = MODE_IDLE;
                        n_hex_cnt   = 2'd0;
                        n_cp        = 16'd0;
                    end
                end
                MODE_HEX: begin
                    if (!hx.ok) begin
                        o_run_valid = 1'b1;
                        o_run.kind  = KIND_ERROR;
                        o_run.err   = ERR_NON_HEX;
                        n_mode      = MODE_IDLE;
                        n_hex_cnt   = 2'd0;
                        n_cp        = 16'd0;
                    end else if (hex_eff == 2'd3) begin
                        o_run_valid = 1'b1;
                        o_run.kind  = KIND_BYTE;
                        n_mode      = MODE_BODY;
                        n_hex_cnt   = 2'd0;
                        n_cp        = 16'd0;
                        if (cp_full < CP_TWO_BYTE) begin
                            o_run.last_idx = 2'd0;
                            o_run.b0       = cp_full[7:0];
                        end else if (cp_full < CP_THREE) begin
                            o_run.last_idx = 2'd1;
                            o_run.b0       = UTF_LEAD2 | {3'd0, cp_full[10:6]};
                            o_run.b1       = UTF_CONT | {2'd0, cp_full[5:0] & UTF_MASK};
                        end else begin
                            o_run.last_idx = 2'd2;
                            o_run.b0       = UTF_LEAD3 | {4'd0, cp_full[15:12]};
                            o_run.b1       = UTF_CONT | {2'd0, cp_full[11:6] & UTF_MASK};
                            o_run.b2       = UTF_CONT | {2'd0, cp_full[5:0] & UTF_MASK};
                        end
                    end else begin
                        n_cp      = cp_full;
                        n_hex_cnt = hex_eff + 2'd1;
                    end
                end
                default: begin
                    o_run_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_hex_cnt <= 2'd0;
            r_cp      <= 16'd0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_cp      <= n_cp;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/jsu_queue.sv =====
`default_nettype none
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  t_run      i_wr_run,
    output logic      o_full,
    input  wire logic i_rd,
    output logic      o_valid,
    output t_run      o_rd_run
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_run          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_en, rd_en;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign wr_en    = i_wr && !o_full;
    assign rd_en    = i_rd && o_valid;
    assign o_rd_run = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/jsu_back.sv =====
`default_nettype none
module jsu_back
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_run_valid,
    input  t_run            i_run,
    output logic            o_run_done,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_kind,
    output logic [2:0]      o_error_code,
    output logic            o_last_of_run
);

    logic       r_valid;
    logic [1:0] r_idx;
    logic [7:0] r_byte;
    logic [1:0] r_kind;
    logic [2:0] r_err;
    logic       r_last;
    logic       load;
    logic       at_end;
    logic [7:0] sel_byte;

    assign load       = i_run_valid && (!r_valid || i_pop);
    assign at_end     = (r_idx == i_run.last_idx);
    assign o_run_done = load && at_end;

    always_comb begin
        unique case (r_idx)
            2'd0:    sel_byte = i_run.b0;
            2'd1:    sel_byte = i_run.b1;
            default: sel_byte = i_run.b2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_kind <= i_run.kind;
            r_err  <= i_run.err;
            r_last <= at_end;
        end
    end

    assign o_empty       = !r_valid;
    assign o_out_byte    = r_byte;
    assign o_kind        = r_kind;
    assign o_error_code  = r_err;
    assign o_last_of_run = r_last;

endmodule
`default_nettype wire

// ===== rtl/json_string_unescape.sv =====
// channel   | handshake         | fields
// input     | i_push / o_full   | i_byte_value, i_start_string, i_text_ended
// result    | o_empty / i_pop   | o_out_byte, o_kind, o_error_code, o_last_of_run
//
// one input word a cycle while the run queue has room; the front decodes each word combinationally
// the first result word of an input word passes through the run queue and then the back's output register
// result words leave one a cycle from the back's output register while pop is held high, so a \u escape
// giving three bytes holds the back until all three have left; queue depth sets the slack
// synchronous active-low reset empties the queue and returns the decoder to idle
// o_full rises once the queue holds QUEUE_DEPTH runs, even for words giving no result
// with pop held low the back keeps its word, the queue fills and input stalls
`default_nettype none
module json_string_unescape
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_start_string,
    input  wire logic       i_text_ended,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_kind,
    output logic [2:0]      o_error_code,
    output logic            o_last_of_run
);

    logic accept;
    logic run_valid;
    t_run run;
    logic q_full;
    logic q_valid;
    t_run q_run;
    logic run_done;

    assign o_full = q_full;
    assign accept = i_push && !q_full;

    jsu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_byte_value   (i_byte_value),
        .i_start_string (i_start_string),
        .i_text_ended   (i_text_ended),
        .o_run_valid    (run_valid),
        .o_run          (run)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (accept && run_valid),
        .i_wr_run (run),
        .o_full   (q_full),
        .i_rd     (run_done),
        .o_valid  (q_valid),
        .o_rd_run (q_run)
    );

    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_run_valid   (q_valid),
        .i_run         (q_run),
        .o_run_done    (run_done),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_out_byte    (o_out_byte),
        .o_kind        (o_kind),
        .o_error_code  (o_error_code),
        .o_last_of_run (o_last_of_run)
    );

endmodule
`default_nettype wire

// ===== rtl/jsu_checker.sv =====
`default_nettype none
module jsu_checker
    import jsu_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_empty,
    input wire logic       i_pop,
    input wire logic [7:0] o_out_byte,
    input wire logic [1:0] o_kind,
    input wire logic [2:0] o_error_code,
    input wire logic       o_last_of_run
);

    // closing quote and errors stand alone in their run
    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind != KIND_BYTE) |-> o_last_of_run)
        else $error("close or error word not last of run");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind != KIND_BYTE) |-> (o_out_byte == 8'd0))
        else $error("nonzero byte on non-byte word");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind != KIND_ERROR) |-> (o_error_code == ERR_NONE))
        else $error("error code set on non-error word");

    // a popped word that does not end its run is followed directly by a further byte word of that run
    a_cont_after_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_last_of_run) |=> (!o_empty && o_kind == KIND_BYTE))
        else $error("run broken off before its last word");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out_byte) && $stable(o_kind)))
        else $error("stalled word changed");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_empty       (o_empty),
    .i_pop         (i_pop),
    .o_out_byte    (o_out_byte),
    .o_kind        (o_kind),
    .o_error_code  (o_error_code),
    .o_last_of_run (o_last_of_run)
);
`default_nettype wire
